FILE: hdl/pce_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pce_pkg: shared types, constants and CRC functions
// Holds the configuration record, the queue entry type, register indexes and
// the byte-parallel CRC update used by the back end.
// ----------------------------------------------------------------------------
package pce_pkg;

   localparam int DATA_W = 8;
   localparam int CRC_W = 32;
   localparam int CSR_IDX_W = 3;

   // Width select codes.
   localparam logic [1:0] WMODE_8 = 2'd0;
   localparam logic [1:0] WMODE_16 = 2'd1;
   localparam logic [1:0] WMODE_32 = 2'd2;

   // Register indexes on the configuration channel.
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH_MODE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GEN_POLY = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_START_VALUE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FINAL_XOR = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_REFLECT_IN = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_REFLECT_OUT = 3'd5;

   // Reset values of the configuration registers.
   localparam logic [1:0] RST_WIDTH_MODE = WMODE_16;
   localparam logic [CRC_W-1:0] RST_GEN_POLY = 32'h0000_8005;
   localparam logic [CRC_W-1:0] RST_START_VALUE = 32'h0000_0000;
   localparam logic [CRC_W-1:0] RST_FINAL_XOR = 32'h0000_0000;

   typedef struct packed {
      logic [1:0]       width_mode;
      logic [CRC_W-1:0] gen_poly;
      logic [CRC_W-1:0] start_value;
      logic [CRC_W-1:0] final_xor;
      logic             reflect_in;
      logic             reflect_out;
   } pce_cfg_type;

   // One classified byte travelling from the front end to the back end.
   typedef struct packed {
      logic [DATA_W-1:0] data;
      logic              last;
      logic              first;
   } pce_item_type;

   function automatic logic [CRC_W-1:0] width_mask(input logic [1:0] mode);
      logic [CRC_W-1:0] m;
      case (mode)
         WMODE_8:  m = 32'h0000_00FF;
         WMODE_16: m = 32'h0000_FFFF;
         default:  m = 32'hFFFF_FFFF;
      endcase
      return m;
   endfunction

   function automatic logic [DATA_W-1:0] mirror8(input logic [DATA_W-1:0] v);
      logic [DATA_W-1:0] r;
      for (int i = 0; i < DATA_W; i++) begin
         r[i] = v[DATA_W-1-i];
      end
      return r;
   endfunction

   // Reverses the remainder across the selected width; v is already masked.
   function automatic logic [CRC_W-1:0] mirror_width(input logic [CRC_W-1:0] v,
                                                     input logic [1:0] mode);
      logic [CRC_W-1:0] r;
      logic [CRC_W-1:0] s;
      for (int i = 0; i < CRC_W; i++) begin
         r[i] = v[CRC_W-1-i];
      end
      case (mode)
         WMODE_8:  s = r >> 24;
         WMODE_16: s = r >> 16;
         default:  s = r;
      endcase
      return s;
   endfunction

   // Folds one byte into the top of the remainder and runs eight shift steps.
   function automatic logic [CRC_W-1:0] crc_fold(input logic [CRC_W-1:0] rem,
                                                 input logic [DATA_W-1:0] data,
                                                 input logic [1:0] mode,
                                                 input logic [CRC_W-1:0] poly);
      logic [CRC_W-1:0] mask;
      logic [CRC_W-1:0] p;
      logic [CRC_W-1:0] crc;
      logic             top;
      mask = width_mask(mode);
      p = poly & mask;
      case (mode)
         WMODE_8:  crc = (rem & mask) ^ {24'b0, data};
         WMODE_16: crc = (rem & mask) ^ {16'b0, data, 8'b0};
         default:  crc = (rem & mask) ^ {data, 24'b0};
      endcase
      for (int i = 0; i < DATA_W; i++) begin
         case (mode)
            WMODE_8:  top = crc[7];
            WMODE_16: top = crc[15];
            default:  top = crc[31];
         endcase
         crc = ((crc << 1) ^ (top ? p : '0)) & mask;
      end
      return crc;
   endfunction

endpackage
`default_nettype wire

FILE: hdl/pce_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pce_if: channel interfaces
// Byte input, CRC result and register write channels, each with valid/ready.
// ----------------------------------------------------------------------------
interface pce_req_if;
   import pce_pkg::*;
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] data_byte;
   logic              last_byte;
   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface pce_rsp_if;
   import pce_pkg::*;
   logic             valid;
   logic             ready;
   logic [CRC_W-1:0] crc_value;
   modport source (output valid, output crc_value, input ready);
   modport sink (input valid, input crc_value, output ready);
endinterface

interface pce_csr_if;
   import pce_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CRC_W-1:0]     wdata;
   modport source (output valid, output index, output wdata, input ready);
   modport sink (input valid, input index, input wdata, output ready);
endinterface
`default_nettype wire

FILE: hdl/parameterized_crc_engine_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// parameterized_crc_engine_unit: configurable 8/16/32-bit CRC engine
// Byte-wide message intake, a short queue and a byte-parallel CRC datapath
// with selectable polynomial, start value, final XOR and reflection.
// ----------------------------------------------------------------------------
//   channel  dir  payload                        transfer when
//   req_bus  in   data_byte[7:0], last_byte      valid && ready
//   rsp_bus  out  crc_value[31:0]                valid && ready
//   csr_bus  in   index[2:0], wdata[31:0]        valid && ready (always ready)
//
// One byte per cycle is sustained while the queue is not full; the CRC
// datapath folds a whole byte in one combinational step. The CRC of a last
// byte is loaded into the result register as that byte leaves the queue.
// Reset is synchronous and empties the queue and result register. When the
// result register is held by a stalled sink, bytes that are not last keep
// flowing and the queue absorbs the rest.
// ----------------------------------------------------------------------------
module parameterized_crc_engine_unit #(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire logic clock,
   input  wire logic reset,
   pce_req_if.sink   req_bus,
   pce_rsp_if.source rsp_bus,
   pce_csr_if.sink   csr_bus
);
   import pce_pkg::*;

   pce_cfg_type  cfg_ff;
   pce_cfg_type  cfg_in;
   pce_item_type push_item;
   pce_item_type pop_item;
   logic         q_push;
   logic         q_full;
   logic         q_pop;
   logic         q_empty;

   assign csr_bus.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_WIDTH_MODE:  cfg_in.width_mode = csr_bus.wdata[1:0];
            CSR_GEN_POLY:    cfg_in.gen_poly = csr_bus.wdata;
            CSR_START_VALUE: cfg_in.start_value = csr_bus.wdata;
            CSR_FINAL_XOR:   cfg_in.final_xor = csr_bus.wdata;
            CSR_REFLECT_IN:  cfg_in.reflect_in = csr_bus.wdata[0];
            CSR_REFLECT_OUT: cfg_in.reflect_out = csr_bus.wdata[0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.width_mode <= RST_WIDTH_MODE;
         cfg_ff.gen_poly <= RST_GEN_POLY;
         cfg_ff.start_value <= RST_START_VALUE;
         cfg_ff.final_xor <= RST_FINAL_XOR;
         cfg_ff.reflect_in <= 1'b0;
         cfg_ff.reflect_out <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   pce_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req    (req_bus),
      .cfg    (cfg_ff),
      .q_full (q_full),
      .q_push (q_push),
      .q_item (push_item)
   );

   pce_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .full      (q_full),
      .pop       (q_pop),
      .pop_item  (pop_item),
      .empty     (q_empty)
   );

   pce_back u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .q_empty (q_empty),
      .q_item  (pop_item),
      .q_pop   (q_pop),
      .rsp     (rsp_bus)
   );

endmodule
`default_nettype wire

FILE: hdl/pce_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pce_front: byte intake
// Accepts message bytes, applies input reflection and marks the first byte
// of each message before handing the byte to the queue.
// ----------------------------------------------------------------------------
module pce_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   pce_req_if.sink                    req,
   input  wire pce_pkg::pce_cfg_type  cfg,
   input  wire logic                  q_full,
   output      logic                  q_push,
   output      pce_pkg::pce_item_type q_item
);
   import pce_pkg::*;

   logic in_msg_ff;
   logic in_msg_in;

   assign req.ready = !q_full;
   assign q_push = req.valid && !q_full;

   always_comb begin
      q_item.data = cfg.reflect_in ? mirror8(req.data_byte) : req.data_byte;
      q_item.last = req.last_byte;
      q_item.first = !in_msg_ff;
   end

   always_comb begin
      in_msg_in = in_msg_ff;
      if (q_push) begin
         in_msg_in = !req.last_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_msg_ff <= 1'b0;
      end else begin
         in_msg_ff <= in_msg_in;
      end
   end

endmodule
`default_nettype wire

FILE: hdl/pce_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pce_fifo: item queue
// Short first-in first-out queue that decouples byte intake from the CRC
// datapath.
// ----------------------------------------------------------------------------
module pce_fifo #(
   parameter int DEPTH = 2
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire pce_pkg::pce_item_type push_item,
   output      logic                  full,
   input  wire logic                  pop,
   output      pce_pkg::pce_item_type pop_item,
   output      logic                  empty
);
   import pce_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   pce_item_type      entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff;
   logic [PTR_W-1:0]  wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff;
   logic [PTR_W-1:0]  rd_ptr_in;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic              do_push;
   logic              do_pop;

   assign full = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop = pop && !empty;
   assign pop_item = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule
`default_nettype wire

FILE: hdl/pce_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pce_back: CRC datapath
// Folds one queued byte per cycle into the running remainder; a last byte
// of a message waits for a free result register, then finishes the CRC into it.
// ----------------------------------------------------------------------------
module pce_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire pce_pkg::pce_cfg_type  cfg,
   input  wire logic                  q_empty,
   input  wire pce_pkg::pce_item_type q_item,
   output      logic                  q_pop,
   pce_rsp_if.source                  rsp
);
   import pce_pkg::*;

   logic [CRC_W-1:0] rem_ff;
   logic [CRC_W-1:0] rem_in;
   logic [CRC_W-1:0] crc_ff;
   logic [CRC_W-1:0] crc_in;
   logic             out_valid_ff;
   logic             out_valid_in;
   logic [CRC_W-1:0] rem_base;
   logic [CRC_W-1:0] rem_next;
   logic [CRC_W-1:0] refl;

   // Bytes that are not last never touch the result register.
   assign q_pop = !q_empty && (!q_item.last || !out_valid_ff || rsp.ready);

   assign rsp.valid = out_valid_ff;
   assign rsp.crc_value = crc_ff;

   always_comb begin
      rem_base = q_item.first ? cfg.start_value : rem_ff;
      rem_next = crc_fold(rem_base, q_item.data, cfg.width_mode, cfg.gen_poly);
      refl = cfg.reflect_out ? mirror_width(rem_next, cfg.width_mode) : rem_next;
   end

   always_comb begin
      rem_in = rem_ff;
      crc_in = crc_ff;
      out_valid_in = out_valid_ff;
      if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
      if (q_pop) begin
         rem_in = rem_next;
         if (q_item.last) begin
            crc_in = (refl ^ cfg.final_xor) & width_mask(cfg.width_mode);
            out_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         rem_ff <= '0;
      end else begin
         out_valid_ff <= out_valid_in;
         rem_ff <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      crc_ff <= crc_in;
   end

endmodule
`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the parameterized CRC engine
// Sends byte messages under many CRC settings, with bursty input and a
// stalling result sink, and checks each CRC against a bit-level prediction.
// ----------------------------------------------------------------------------
module tb;
   import pce_pkg::*;

   localparam logic [1:0] WMODE_32_ALT = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_6 = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_7 = 3'd7;
   localparam int RANDOM_BYTES = 1750;
   localparam int SETTLE_CYCLES = 8;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int CYCLE_LIMIT = 300000;

   typedef struct {
      logic [7:0] data;
      logic       last;
   } msg_byte_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   pce_req_if req_bus();
   pce_rsp_if rsp_bus();
   pce_csr_if csr_bus();

   parameterized_crc_engine_unit i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // Predicted copy of the configuration and message state.
   logic [1:0]  cfg_width_mode = RST_WIDTH_MODE;
   logic [31:0] cfg_poly = RST_GEN_POLY;
   logic [31:0] cfg_start = RST_START_VALUE;
   logic [31:0] cfg_xorout = RST_FINAL_XOR;
   logic        cfg_refin = 1'b0;
   logic        cfg_refout = 1'b0;
   logic [31:0] crc_remainder = '0;
   logic        in_message = 1'b0;

   logic [31:0]  crc_expected[$];
   msg_byte_type byte_backlog[$];
   int           bytes_queued = 0;
   int           mismatch_count = 0;
   int           cycle_count = 0;

   // Traffic shaping controls, written by the stimulus after a rising edge.
   logic sender_gappy = 1'b0;
   int   sink_mode = 0;
   int   hold_trigger = 0;

   logic         req_fire = 1'b0;
   msg_byte_type next_byte;
   int           burst_left = 0;
   int           gap_left = 0;
   int           hold_seen = 0;
   int           hold_left = 0;
   int           stall_phase = 0;

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d CRCs outstanding", $time, crc_expected.size());
         $display("Mismatches found");
         $finish;
      end
   end

   function automatic void crc_predict_byte(input logic [7:0] data, input logic last);
      int unsigned nbits;
      logic [31:0] mask;
      logic [31:0] poly;
      logic [31:0] topbit;
      logic [31:0] crc;
      logic [31:0] mirrored;
      logic [7:0]  b;
      case (cfg_width_mode)
         WMODE_8:  nbits = 8;
         WMODE_16: nbits = 16;
         default:  nbits = 32;
      endcase
      mask = (nbits == 32) ? 32'hFFFF_FFFF : ((32'd1 << nbits) - 32'd1);
      topbit = 32'd1 << (nbits - 1);
      poly = cfg_poly & mask;
      if (!in_message) crc_remainder = cfg_start & mask;
      b = data;
      if (cfg_refin) begin
         for (int i = 0; i < 8; i++) b[i] = data[7-i];
      end
      crc = (crc_remainder & mask) ^ ({24'b0, b} << (nbits - 8));
      for (int i = 0; i < 8; i++) begin
         if ((crc & topbit) != 0) crc = ((crc << 1) ^ poly) & mask;
         else crc = (crc << 1) & mask;
      end
      crc_remainder = crc;
      if (!last) begin
         in_message = 1'b1;
         return;
      end
      in_message = 1'b0;
      if (cfg_refout) begin
         mirrored = '0;
         for (int i = 0; i < nbits; i++) mirrored[i] = crc[nbits-1-i];
         crc = mirrored;
      end
      crc_expected.push_back((crc ^ cfg_xorout) & mask);
   endfunction

   // Result check first, then prediction for the byte taken on the same edge.
   always @(posedge clock) begin
      req_fire <= req_bus.valid && req_bus.ready;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (crc_expected.size() == 0) begin
               $display("%0t: unexpected CRC, expected none, actual %08h",
                        $time, rsp_bus.crc_value);
               mismatch_count++;
            end else if (rsp_bus.crc_value !== crc_expected[0]) begin
               $display("%0t: crc_value mismatch, expected %08h, actual %08h",
                        $time, crc_expected[0], rsp_bus.crc_value);
               mismatch_count++;
               void'(crc_expected.pop_front());
            end else begin
               void'(crc_expected.pop_front());
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            crc_predict_byte(req_bus.data_byte, req_bus.last_byte);
         end
      end
   end

   // Byte driver: holds an offered byte until its transfer, then picks the next.
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_fire) begin
         if (gap_left > 0) begin
            gap_left--;
            req_bus.valid <= 1'b0;
         end else if (byte_backlog.size() != 0) begin
            next_byte = byte_backlog.pop_front();
            req_bus.valid <= 1'b1;
            req_bus.data_byte <= next_byte.data;
            req_bus.last_byte <= next_byte.last;
            if (sender_gappy) begin
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 16);
                  gap_left = $urandom_range(0, 6);
               end else begin
                  burst_left--;
               end
            end
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Result sink: its own stall pattern, plus a long hold-off on request.
   always @(negedge clock) begin
      stall_phase = (stall_phase + 1) % 7;
      if (hold_trigger != hold_seen) begin
         hold_seen = hold_trigger;
         hold_left = LONG_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else begin
         case (sink_mode)
            0:       rsp_bus.ready <= 1'b1;
            1:       rsp_bus.ready <= ($urandom_range(0, 1) == 1);
            2:       rsp_bus.ready <= (stall_phase > 2);
            default: rsp_bus.ready <= ($urandom_range(0, 7) != 0);
         endcase
      end
   end

   function automatic void queue_byte(input logic [7:0] data, input logic last);
      msg_byte_type item;
      item.data = data;
      item.last = last;
      byte_backlog.push_back(item);
      bytes_queued++;
   endfunction

   function automatic void queue_message(input int len);
      for (int i = 0; i < len; i++) queue_byte(8'($urandom_range(0, 255)), i == len - 1);
   endfunction

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] value);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.wdata <= value;
      do @(posedge clock); while (!csr_bus.ready);
      case (idx)
         CSR_WIDTH_MODE:  cfg_width_mode = value[1:0];
         CSR_GEN_POLY:    cfg_poly = value;
         CSR_START_VALUE: cfg_start = value;
         CSR_FINAL_XOR:   cfg_xorout = value;
         CSR_REFLECT_IN:  cfg_refin = value[0];
         CSR_REFLECT_OUT: cfg_refout = value[0];
         default: ;
      endcase
   endtask

   task automatic csr_release();
      @(negedge clock);
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   // Upper bits of the narrow registers carry junk when junk is set.
   task automatic write_crc_setup(input logic [1:0] mode, input logic [31:0] poly,
                                  input logic [31:0] start, input logic [31:0] xorout,
                                  input logic refin, input logic refout, input logic junk);
      logic [31:0] filler;
      filler = junk ? $urandom : 32'd0;
      csr_write(CSR_WIDTH_MODE, {filler[31:2], mode});
      csr_write(CSR_GEN_POLY, poly);
      csr_write(CSR_START_VALUE, start);
      csr_write(CSR_FINAL_XOR, xorout);
      filler = junk ? $urandom : 32'd0;
      csr_write(CSR_REFLECT_IN, {filler[31:1], refin});
      filler = junk ? $urandom : 32'd0;
      csr_write(CSR_REFLECT_OUT, {filler[31:1], refout});
      csr_release();
   endtask

   // Waits until every byte is taken and every CRC is out, then lets the
   // pipeline settle so no byte is still in flight before a register write.
   task automatic wait_until_drained();
      while (byte_backlog.size() != 0 || req_bus.valid || crc_expected.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_word();
      logic [31:0] w;
      case ($urandom_range(0, 3))
         0:       w = 32'h0000_0000;
         1:       w = 32'hFFFF_FFFF;
         default: w = $urandom;
      endcase
      return w;
   endfunction

   function automatic logic [31:0] pick_poly();
      logic [31:0] p;
      case ($urandom_range(0, 6))
         0:       p = 32'h0000_0007;
         1:       p = 32'h0000_8005;
         2:       p = 32'h04C1_1DB7;
         3:       p = 32'h0000_0000;
         4:       p = 32'hFFFF_FFFF;
         default: p = $urandom;
      endcase
      return p;
   endfunction

   initial begin
      int phase;
      int n_msgs;
      int len;
      logic [7:0] check_str[9];
      req_bus.valid = 1'b0;
      req_bus.data_byte = '0;
      req_bus.last_byte = 1'b0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = '0;
      csr_bus.wdata = '0;
      check_str = '{8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39};

      wait (!reset);
      @(posedge clock);

      // Reset settings, single-byte messages at the byte extremes, then the
      // usual check string.
      sink_mode = 0;
      queue_byte(8'h00, 1'b1);
      queue_byte(8'hFF, 1'b1);
      for (int i = 0; i < 9; i++) queue_byte(check_str[i], i == 8);
      wait_until_drained();

      // Width code three behaves as 32 bits, reflected both ways.
      write_crc_setup(WMODE_32_ALT, 32'h04C1_1DB7, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                      1'b1, 1'b1, 1'b0);
      queue_byte(8'h00, 1'b0);
      queue_byte(8'hFF, 1'b0);
      queue_byte(8'h80, 1'b0);
      queue_byte(8'h01, 1'b1);
      wait_until_drained();

      // Width and polynomial change partway through a message.
      write_crc_setup(WMODE_32, 32'h04C1_1DB7, 32'h1234_5678, 32'h0000_0000,
                      1'b0, 1'b0, 1'b0);
      queue_message(3);
      void'(byte_backlog.pop_back());
      bytes_queued--;
      queue_byte(8'($urandom_range(0, 255)), 1'b0);
      wait_until_drained();
      csr_write(CSR_WIDTH_MODE, {30'b0, WMODE_8});
      csr_write(CSR_GEN_POLY, 32'h0000_0007);
      csr_release();
      queue_message(2);
      wait_until_drained();

      // Unused register slots are ignored; then 8-bit polynomial extremes.
      csr_write(CSR_SPARE_6, $urandom);
      csr_write(CSR_SPARE_7, $urandom);
      csr_release();
      write_crc_setup(WMODE_8, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000,
                      1'b0, 1'b1, 1'b1);
      queue_byte(8'hFF, 1'b1);
      wait_until_drained();
      csr_write(CSR_GEN_POLY, 32'h0000_0000);
      csr_release();
      queue_byte(8'h80, 1'b1);
      wait_until_drained();

      phase = 0;
      while (bytes_queued < RANDOM_BYTES) begin
         write_crc_setup(2'($urandom_range(0, 3)), pick_poly(), pick_word(), pick_word(),
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)));
         sender_gappy = ($urandom_range(0, 3) != 0);
         sink_mode = $urandom_range(0, 3);
         if (phase == 3) begin
            // Back-to-back single-byte messages against a sink that holds off,
            // so results pile up and the input side stalls.
            sender_gappy = 1'b0;
            hold_trigger++;
            for (int i = 0; i < 60; i++) queue_message(1);
         end else begin
            n_msgs = $urandom_range(5, 20);
            for (int i = 0; i < n_msgs; i++) begin
               if ($urandom_range(0, 9) == 0) len = $urandom_range(9, 40);
               else len = $urandom_range(1, 8);
               queue_message(len);
            end
            // Sometimes leave a message open so the next settings apply to
            // its remaining bytes.
            if ($urandom_range(0, 3) == 0) begin
               len = $urandom_range(1, 5);
               for (int i = 0; i < len; i++) queue_byte(8'($urandom_range(0, 255)), 1'b0);
            end
         end
         wait_until_drained();
         phase++;
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (crc_expected.size() != 0) begin
         $display("%0t: %0d CRCs never arrived, expected %08h, actual none",
                  $time, crc_expected.size(), crc_expected[0]);
         mismatch_count++;
      end
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

FILE: files.f
hdl/pce_pkg.sv
hdl/pce_if.sv
hdl/pce_front.sv
hdl/pce_fifo.sv
hdl/pce_back.sv
hdl/parameterized_crc_engine_unit.sv
tb/tb.sv
